/* sv/pftm_pkg.sv */
// shared types, constants and coefficient rom of the friction torque model
`default_nettype none

package pftm_pkg;

  // field widths
  localparam int unsigned MotorW  = 3;
  localparam int unsigned VelW    = 24;
  localparam int unsigned VextW   = 25;
  localparam int unsigned ThrW    = 23;
  localparam int unsigned TorqueW = 24;
  localparam int unsigned CoefW   = 30;
  localparam int unsigned CsetW   = 4;
  localparam int unsigned CidxW   = 3;
  localparam int unsigned AccW    = 40;
  localparam int unsigned AccHiW  = 20;
  localparam int unsigned AccLoW  = 20;
  localparam int unsigned PhiW    = VextW + AccHiW;
  localparam int unsigned PloW    = VextW + AccLoW + 1;
  localparam int unsigned SumW    = 66;
  localparam int unsigned RndW    = AccW + 1;

  // region codes
  localparam logic [1:0] RegQuartic = 2'd0;
  localparam logic [1:0] RegPos     = 2'd1;
  localparam logic [1:0] RegNeg     = 2'd2;
  localparam logic [1:0] RegUnknown = 2'd3;

  // coefficient set codes: quartic sets first, then quadratic sets
  localparam logic [CsetW-1:0] CsetQuadBase = 4'd4;

  // limits
  localparam logic [ThrW-1:0]       ThrReset   = 23'd32768;
  localparam logic signed [SumW-1:0] AccLimPos = 66'sd274877906944;
  localparam logic signed [SumW-1:0] AccLimNeg = -66'sd274877906944;
  localparam logic signed [RndW-1:0] RoundHalf = 41'sd8192;
  localparam logic signed [RndW-1:0] TorqueMax = 41'sd8388607;
  localparam logic signed [RndW-1:0] TorqueMin = -41'sd8388608;

  // quadratic sets {a, b, c}, Q.30
  localparam logic signed [CoefW-1:0] QuadRom [5][3] = '{
    '{ 30'sd1268968,  -30'sd2202798, 30'sd63119750  },
    '{ -30'sd1106279, 30'sd9316175,  30'sd100878370 },
    '{ -30'sd260301,  30'sd4535746,  30'sd63324738  },
    '{ 30'sd32538,    30'sd3719051,  30'sd50218580  },
    '{ -30'sd780903,  30'sd8310111,  30'sd45949643  }
  };

  // quartic sets {q1, q2, q3, q4}, Q.30
  localparam logic signed [CoefW-1:0] QuartRom [4][4] = '{
    '{ 30'sd188108179, -30'sd1268968,  -30'sd253747969, 30'sd5075870   },
    '{ 30'sd252929648, 30'sd157222484, -30'sd328568903, -30'sd311031120 },
    '{ 30'sd154399194, -30'sd32538,    -30'sd200906857, 30'sd130151    },
    '{ 30'sd145573361, 30'sd780903,    -30'sd183017667, -30'sd3123613   }
  };

  typedef struct packed {
    logic [MotorW-1:0]      motor_index;
    logic signed [VelW-1:0] velocity;
  } in_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] friction_torque;
    logic [1:0]                region;
    logic                      saturated;
  } out_t;

  // control travelling down the pipeline with each item
  typedef struct packed {
    logic                    valid;
    logic [1:0]              region;
    logic [CsetW-1:0]        cset;
    logic signed [VextW-1:0] v;
  } ctl_t;

  // coefficient of power idx (0 to 4) for a set, both kinds padded to degree four
  function automatic logic signed [CoefW-1:0] poly_coef(input logic [CsetW-1:0] cset,
                                                        input logic [CidxW-1:0] idx);
    logic signed [CoefW-1:0] c;
    logic [CsetW-1:0]        s;
    c = '0;
    s = cset - CsetQuadBase;
    if (cset < CsetQuadBase) begin
      case (idx)
        3'd4:    c = QuartRom[cset[1:0]][3];
        3'd3:    c = QuartRom[cset[1:0]][2];
        3'd2:    c = QuartRom[cset[1:0]][1];
        3'd1:    c = QuartRom[cset[1:0]][0];
        default: c = '0;
      endcase
    end else if (s < 4'd5) begin
      case (idx)
        3'd2:    c = QuadRom[s[2:0]][0];
        3'd1:    c = QuadRom[s[2:0]][1];
        3'd0:    c = QuadRom[s[2:0]][2];
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/pftm_decode.sv */
// entry stage: threshold register, region choice and coefficient set selection
`default_nettype none

module pftm_decode
  import pftm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ThrW-1:0]         cfg_wdata_i,
  input  wire logic                    in_valid_i,
  input  wire in_t                     in_i,
  output ctl_t                         ctl_o,
  output logic signed [AccW-1:0]       acc_o
);

  logic [ThrW-1:0]          thr_q;
  ctl_t                     ctl_d, ctl_q;
  logic signed [AccW-1:0]   acc_d, acc_q;
  logic signed [VextW-1:0]  v_ext, thr_ext, thr_neg;
  logic signed [CoefW-1:0]  c_top;
  logic [CsetW-1:0]         pos_cset, neg_cset;

  // speed threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign v_ext   = {in_i.velocity[VelW-1], in_i.velocity};
  assign thr_ext = {2'b00, thr_q};
  assign thr_neg = -thr_ext;

  // motor 1 has distinct outward and inward quadratics
  always_comb begin
    case (in_i.motor_index[1:0])
      2'd0:    begin pos_cset = CsetQuadBase + 4'd0; neg_cset = CsetQuadBase + 4'd0; end
      2'd1:    begin pos_cset = CsetQuadBase + 4'd1; neg_cset = CsetQuadBase + 4'd2; end
      2'd2:    begin pos_cset = CsetQuadBase + 4'd3; neg_cset = CsetQuadBase + 4'd3; end
      default: begin pos_cset = CsetQuadBase + 4'd4; neg_cset = CsetQuadBase + 4'd4; end
    endcase
  end

  // region choice and velocity fed to the evaluator
  always_comb begin
    ctl_d.valid = in_valid_i;
    ctl_d.region = RegQuartic;
    ctl_d.cset   = {1'b0, in_i.motor_index};
    ctl_d.v      = v_ext;
    if (in_i.motor_index[2]) begin
      ctl_d.region = RegUnknown;
      ctl_d.cset   = '0;
      ctl_d.v      = '0;
    end else if (v_ext >= thr_ext) begin
      ctl_d.region = RegPos;
      ctl_d.cset   = pos_cset;
    end else if (v_ext < thr_neg) begin
      ctl_d.region = RegNeg;
      ctl_d.cset   = neg_cset;
      ctl_d.v      = -v_ext;
    end
  end

  // leading coefficient seeds the accumulator
  assign c_top = poly_coef(ctl_d.cset, 3'd4);
  assign acc_d = {{(AccW-CoefW){c_top[CoefW-1]}}, c_top};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* sv/pftm_horner_step.sv */
// one horner step: split multiply stage, then shift, add coefficient and clamp
`default_nettype none

module pftm_horner_step
  import pftm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [CidxW-1:0]        coef_idx_i,
  input  wire ctl_t                    ctl_i,
  input  wire logic signed [AccW-1:0]  acc_i,
  output ctl_t                         ctl_o,
  output logic signed [AccW-1:0]       acc_o
);

  logic signed [AccHiW-1:0]  acc_hi;
  logic signed [AccLoW:0]    acc_lo;
  logic signed [PhiW-1:0]    p_hi_d, p_hi_q;
  logic signed [PloW-1:0]    p_lo_d, p_lo_q;
  ctl_t                      ctl_a_q, ctl_b_q;
  logic signed [SumW-1:0]    hi_ext, lo_ext, prod, prod_sh, coef_ext, t;
  logic signed [CoefW-1:0]   coef;
  logic signed [AccW-1:0]    acc_d, acc_q;

  // partial products over the upper and lower halves of the accumulator
  assign acc_hi = acc_i[AccW-1:AccLoW];
  assign acc_lo = {1'b0, acc_i[AccLoW-1:0]};
  assign p_hi_d = $signed(ctl_i.v) * acc_hi;
  assign p_lo_d = $signed(ctl_i.v) * acc_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_hi_q <= p_hi_d;
    p_lo_q <= p_lo_d;
    acc_q  <= acc_d;
  end

  // recombine, floor shift, add coefficient
  assign hi_ext   = {p_hi_q[PhiW-1], p_hi_q, {AccLoW{1'b0}}};
  assign lo_ext   = {{(SumW-PloW){p_lo_q[PloW-1]}}, p_lo_q};
  assign prod     = hi_ext + lo_ext;
  assign prod_sh  = prod >>> 16;
  assign coef     = poly_coef(ctl_a_q.cset, coef_idx_i);
  assign coef_ext = {{(SumW-CoefW){coef[CoefW-1]}}, coef};
  assign t        = prod_sh + coef_ext;

  // clamp keeps the sign and lies far outside the torque range
  always_comb begin
    if (t > AccLimPos) begin
      acc_d = AccLimPos[AccW-1:0];
    end else if (t < AccLimNeg) begin
      acc_d = AccLimNeg[AccW-1:0];
    end else begin
      acc_d = t[AccW-1:0];
    end
  end

  assign ctl_o = ctl_b_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* sv/pftm_round_sat.sv */
// output stage: sign for the negative region, round to q8.16, saturate
`default_nettype none

module pftm_round_sat
  import pftm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctl_t                    ctl_i,
  input  wire logic signed [AccW-1:0]  acc_i,
  output logic                         valid_o,
  output out_t                         res_o
);

  logic signed [RndW-1:0] f, fr, r;
  out_t                   res_d, res_q;
  logic                   valid_q;

  assign f  = (ctl_i.region == RegNeg) ? -{acc_i[AccW-1], acc_i} : {acc_i[AccW-1], acc_i};
  assign fr = f + RoundHalf;
  assign r  = fr >>> 14;

  // saturation and unknown motor override
  always_comb begin
    res_d.region = ctl_i.region;
    if (ctl_i.region == RegUnknown) begin
      res_d.friction_torque = '0;
      res_d.saturated       = 1'b0;
    end else if (r > TorqueMax) begin
      res_d.friction_torque = TorqueMax[TorqueW-1:0];
      res_d.saturated       = 1'b1;
    end else if (r < TorqueMin) begin
      res_d.friction_torque = TorqueMin[TorqueW-1:0];
      res_d.saturated       = 1'b1;
    end else begin
      res_d.friction_torque = r[TorqueW-1:0];
      res_d.saturated       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* sv/piecewise_friction_torque_model.sv */
// top level of the piecewise friction compensation torque pipeline
//
// An item (motor index, signed q8.16 velocity) is taken at a rising edge with
// start high and busy low. busy is always low: a new item may enter every cycle.
// Each result (torque, region, saturated) appears on res_o for one cycle with
// done_o high, in the order in which the items were taken.
// Pipeline: one decode stage (threshold compare, coefficient set choice), four
// horner steps of two stages each (split 25x20 multiplies, then shift, add,
// clamp), one rounding and saturation stage. Throughput is one item per cycle,
// set by the four chained horner units, each with its own multipliers.
// The speed threshold is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while no item is in flight, as the block does not enforce it.
// Reset restores the threshold to 0.5 rev/s and clears all valid bits; items in
// flight are dropped.
// The receiver cannot stall: done_o is a strobe and nothing is held back.
`default_nettype none

module piecewise_friction_torque_model
  import pftm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ThrW-1:0]   cfg_wdata_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               in_i,
  output logic                   done_o,
  output out_t                   res_o
);

  ctl_t                   ctl_s [5];
  logic signed [AccW-1:0] acc_s [5];

  assign busy = 1'b0;

  // decode stage
  pftm_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (start & ~busy),
    .in_i        (in_i),
    .ctl_o       (ctl_s[0]),
    .acc_o       (acc_s[0])
  );

  // four horner steps, coefficient powers three down to zero
  for (genvar k = 0; k < 4; k++) begin : g_step
    pftm_horner_step u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .coef_idx_i (CidxW'(3 - k)),
      .ctl_i      (ctl_s[k]),
      .acc_i      (acc_s[k]),
      .ctl_o      (ctl_s[k+1]),
      .acc_o      (acc_s[k+1])
    );
  end

  // rounding and saturation
  pftm_round_sat u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_s[4]),
    .acc_i   (acc_s[4]),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  // every accepted item gives a result after the pipeline latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##10 done_o)
    else $error("accepted item produced no result");

  // no result without a matching item taken earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 10))
    else $error("result without a matching item");

  // unknown motor gives zero torque, no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.region == RegUnknown) |->
      (res_o.friction_torque == '0 && !res_o.saturated))
    else $error("unknown motor result not zero");

  // a saturated result sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.saturated) |->
      (res_o.friction_torque == TorqueMax[TorqueW-1:0] ||
       res_o.friction_torque == TorqueMin[TorqueW-1:0]))
    else $error("saturated flag with torque inside range");

endmodule

`default_nettype wire
